### src/tlvp_pkg.sv
// shared types and codes for the tlv field stream parser
package tlvp_pkg;

    localparam int HEADER_BYTES = 4;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 2;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FIELD_LIMIT      = 2'd0,
        REG_VALUE_SIZE_LIMIT = 2'd1,
        REG_STRICT_END       = 2'd2,
        REG_HEADER_BIG       = 2'd3
    } cfg_index_t;

    // reset values of the configuration registers
    localparam logic [10:0] FIELD_LIMIT_RST      = 11'd1024;
    localparam logic [15:0] VALUE_SIZE_LIMIT_RST = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_HEADER = 2'b01,
        PH_VALUE  = 2'b10
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_EMPTY  = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TRUNC_HEADER = 3'd1,
        ST_TOO_MANY     = 3'd2,
        ST_TOO_LARGE    = 3'd3,
        ST_TRUNC_VALUE  = 3'd4
    } status_t;

    typedef struct packed {
        logic [10:0] field_limit;
        logic [15:0] value_size_limit;
        logic        strict_end;
        logic        header_big_endian;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  header_count;
        logic [15:0] type_word;
        logic [15:0] length_word;
        logic [15:0] bytes_left;
        logic        discarding;
    } parse_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] record_type;
        logic [15:0] record_length;
        logic [15:0] value_offset;
        logic [7:0]  value_byte;
        logic        field_done;
        logic [9:0]  field_number;
        logic        parse_done;
        status_t     status;
    } result_t;

endpackage

### src/tlvp_cfg_regs.sv
// configuration registers of the tlv field stream parser
module tlvp_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [tlvp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tlvp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output tlvp_pkg::cfg_t                    cfg
);
    import tlvp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                REG_FIELD_LIMIT:      cfg_next.field_limit       = cfg_data[10:0];
                REG_VALUE_SIZE_LIMIT: cfg_next.value_size_limit  = cfg_data[15:0];
                REG_STRICT_END:       cfg_next.strict_end        = cfg_data[0];
                REG_HEADER_BIG:       cfg_next.header_big_endian = cfg_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.field_limit       <= FIELD_LIMIT_RST;
            cfg_reg.value_size_limit  <= VALUE_SIZE_LIMIT_RST;
            cfg_reg.strict_end        <= 1'b1;
            cfg_reg.header_big_endian <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/tlvp_step.sv
// per-byte parse step: next parser state and the result for one byte
module tlvp_step #(
    parameter int FIELD_CAP = 1024,
    parameter int FW        = 11
) (
    input  tlvp_pkg::cfg_t         cfg,
    input  tlvp_pkg::parse_state_t st,
    input  logic [FW-1:0]          fields_seen,
    input  logic [7:0]             data_byte,
    input  logic                   at_end,
    output tlvp_pkg::parse_state_t st_next,
    output logic [FW-1:0]          fields_seen_next,
    output logic                   res_valid,
    output tlvp_pkg::result_t      res
);
    import tlvp_pkg::*;

    localparam int CW = (FW > 11) ? FW : 11;
    localparam logic [CW-1:0] FIELD_CAP_C = CW'(FIELD_CAP);

    logic [CW-1:0] fs_ext;
    logic [CW-1:0] limit_ext;
    logic [CW-1:0] flim_ext;

    assign fs_ext    = CW'(fields_seen);
    assign flim_ext  = CW'(cfg.field_limit);
    assign limit_ext = (flim_ext < FIELD_CAP_C) ? flim_ext : FIELD_CAP_C;

    always_comb
    begin
        logic [15:0] tw;
        logic [15:0] lw;
        logic        hi_lane;
        logic [15:0] offset;
        logic        last;

        st_next          = st;
        fields_seen_next = fields_seen;
        res_valid        = 1'b0;
        res.kind          = KIND_STATUS;
        res.record_type   = '0;
        res.record_length = '0;
        res.value_offset  = '0;
        res.value_byte    = '0;
        res.field_done    = 1'b0;
        res.field_number  = fs_ext[9:0];
        res.parse_done    = 1'b0;
        res.status        = ST_OK;

        tw      = st.type_word;
        lw      = st.length_word;
        hi_lane = st.header_count[0] ^ cfg.header_big_endian;
        offset  = st.length_word - st.bytes_left;
        last    = (st.bytes_left <= 16'd1);

        if (st.discarding)
        begin
            // drop bytes until the buffer ends
            if (at_end)
            begin
                st_next          = '{PH_HEADER, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0};
                fields_seen_next = '0;
            end
        end
        else
        begin
            case (st.phase)
                PH_HEADER:
                begin
                    // place the byte into its lane of the type or length word
                    if (!st.header_count[1])
                    begin
                        if (hi_lane) tw[15:8] = data_byte;
                        else         tw[7:0]  = data_byte;
                    end
                    else
                    begin
                        if (hi_lane) lw[15:8] = data_byte;
                        else         lw[7:0]  = data_byte;
                    end
                    st_next.type_word   = tw;
                    st_next.length_word = lw;

                    if (st.header_count != 2'(HEADER_BYTES - 1))
                    begin
                        st_next.header_count = st.header_count + 2'd1;
                        // header cut short at buffer end
                        if (at_end)
                        begin
                            res_valid        = 1'b1;
                            res.parse_done   = 1'b1;
                            res.status       = cfg.strict_end ? ST_TRUNC_HEADER : ST_OK;
                            st_next          = '{PH_HEADER, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0};
                            fields_seen_next = '0;
                        end
                    end
                    else
                    begin
                        st_next.header_count = 2'd0;
                        if (fs_ext >= limit_ext || lw > cfg.value_size_limit
                            || (lw != 16'd0 && at_end))
                        begin
                            // header errors: field count first, then size, then cut value
                            res_valid         = 1'b1;
                            res.record_type   = tw;
                            res.record_length = lw;
                            res.parse_done    = 1'b1;
                            if (fs_ext >= limit_ext)
                                res.status = ST_TOO_MANY;
                            else if (lw > cfg.value_size_limit)
                                res.status = ST_TOO_LARGE;
                            else
                                res.status = ST_TRUNC_VALUE;
                            st_next          = '{PH_HEADER, 2'd0, 16'd0, 16'd0, 16'd0, !at_end};
                            fields_seen_next = '0;
                        end
                        else if (lw == 16'd0)
                        begin
                            // empty field marker
                            res_valid         = 1'b1;
                            res.kind          = KIND_EMPTY;
                            res.record_type   = tw;
                            res.field_done    = 1'b1;
                            res.parse_done    = at_end;
                            st_next.type_word = 16'd0;
                            fields_seen_next  = fields_seen + 1'b1;
                            if (at_end)
                            begin
                                st_next          = '{PH_HEADER, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0};
                                fields_seen_next = '0;
                            end
                        end
                        else
                        begin
                            st_next.phase      = PH_VALUE;
                            st_next.bytes_left = lw;
                        end
                    end
                end

                PH_VALUE:
                begin
                    // value byte out with its field context
                    res_valid         = 1'b1;
                    res.kind          = KIND_BYTE;
                    res.record_type   = st.type_word;
                    res.record_length = st.length_word;
                    res.value_offset  = offset;
                    res.value_byte    = data_byte;
                    if (last)
                    begin
                        res.field_done   = 1'b1;
                        res.parse_done   = at_end;
                        st_next          = '{PH_HEADER, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0};
                        fields_seen_next = at_end ? '0 : fields_seen + 1'b1;
                    end
                    else if (at_end)
                    begin
                        // value cut short by buffer end
                        res.parse_done   = 1'b1;
                        res.status       = ST_TRUNC_VALUE;
                        st_next          = '{PH_HEADER, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0};
                        fields_seen_next = '0;
                    end
                    else
                    begin
                        st_next.bytes_left = st.bytes_left - 16'd1;
                    end
                end

                default:
                begin
                    st_next          = '{PH_HEADER, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0};
                    fields_seen_next = '0;
                end
            endcase
        end
    end

endmodule

### src/tlv_field_stream_parser_unit.sv
// top level of the tlv field stream parser: input register, parse state, result register
//
// Parses a byte stream of type-length-value records (16-bit type, 16-bit
// length, then the value bytes), one byte per request, with buffer_end on the
// final byte. Each value byte comes out with its field's type, length, offset
// and index; an empty field gives one marker; header errors and partial
// headers give one status result, after which any bytes up to the buffer
// end are dropped; a value cut short puts a truncation status on its last
// byte's result. The block takes one byte every cycle while in_stall is low:
// each byte is parsed out of the input register and its result is loaded
// into the result register, from which it is offered. A result waiting in
// the result register holds the input only while the byte in the input
// register makes a result of its own. No clearing pass is needed after reset.
module tlv_field_stream_parser_unit #(
    parameter int FIELD_CAP = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_write,
    input  logic [tlvp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tlvp_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       data_in,
    input  logic                             buffer_end,
    // output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       kind,
    output logic [15:0]                      record_type,
    output logic [15:0]                      record_length,
    output logic [15:0]                      value_offset,
    output logic [7:0]                       value_byte,
    output logic                             field_done,
    output logic [9:0]                       field_number,
    output logic                             parse_done,
    output logic [2:0]                       status
);
    import tlvp_pkg::*;

    localparam int FW = $clog2(FIELD_CAP + 1);

    cfg_t         cfg;
    parse_state_t st_reg;
    parse_state_t st_next;
    logic [FW-1:0] fs_reg;
    logic [FW-1:0] fs_next;
    logic          res_valid;
    result_t       res;

    logic          in_valid_reg;
    logic [7:0]    data_reg;
    logic          end_reg;
    logic          out_valid_reg;
    result_t       out_reg;
    logic          out_free;
    logic          fire;
    logic          in_take;

    tlvp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tlvp_step #(
        .FIELD_CAP (FIELD_CAP),
        .FW        (FW)
    ) u_step (
        .cfg              (cfg),
        .st               (st_reg),
        .fields_seen      (fs_reg),
        .data_byte        (data_reg),
        .at_end           (end_reg),
        .st_next          (st_next),
        .fields_seen_next (fs_next),
        .res_valid        (res_valid),
        .res              (res)
    );

    // handshake: a byte is parsed when its result has room or it makes none
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && (out_free || !res_valid);
    assign in_stall = in_valid_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            data_reg <= data_in;
            end_reg  <= buffer_end;
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{PH_HEADER, 2'd0, 16'd0, 16'd0, 16'd0, 1'b0};
            fs_reg <= '0;
        end
        else if (fire)
        begin
            st_reg <= st_next;
            fs_reg <= fs_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fire && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_reg.kind;
    assign record_type   = out_reg.record_type;
    assign record_length = out_reg.record_length;
    assign value_offset  = out_reg.value_offset;
    assign value_byte    = out_reg.value_byte;
    assign field_done    = out_reg.field_done;
    assign field_number  = out_reg.field_number;
    assign parse_done    = out_reg.parse_done;
    assign status        = out_reg.status;

endmodule

### tb/tb_tlv_field_stream_parser_unit.sv
// self-checking testbench for the tlv field stream parser unit
`timescale 1ns / 100ps

module tb_tlv_field_stream_parser_unit;
    import tlvp_pkg::*;

    localparam int FIELD_CAP    = 1024;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        cfg_write    = 1'b0;
    cfg_index_t  cfg_index    = REG_FIELD_LIMIT;
    logic [15:0] cfg_data     = '0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [7:0]  data_in      = '0;
    logic        buffer_end   = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [1:0]  kind;
    logic [15:0] record_type;
    logic [15:0] record_length;
    logic [15:0] value_offset;
    logic [7:0]  value_byte;
    logic        field_done;
    logic [9:0]  field_number;
    logic        parse_done;
    logic [2:0]  status;

    // traffic shaping knobs
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_request = 1'b0;
    logic hold_on = 1'b0;

    int fail_count = 0;
    int items_sent = 0;
    int cycle_count = 0;

    // mirror of the parser state and register settings
    cfg_t        cfg_mirror;
    phase_t      parse_phase;
    logic [1:0]  hdr_count;
    logic [15:0] type_acc;
    logic [15:0] length_acc;
    logic [15:0] value_left;
    logic [10:0] field_count;
    logic        dropping;

    result_t     expected_results[$];
    logic [7:0]  buffer_bytes[$];

    tlv_field_stream_parser_unit #(
        .FIELD_CAP(FIELD_CAP)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_in      (data_in),
        .buffer_end   (buffer_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .record_type  (record_type),
        .record_length(record_length),
        .value_offset (value_offset),
        .value_byte   (value_byte),
        .field_done   (field_done),
        .field_number (field_number),
        .parse_done   (parse_done),
        .status       (status)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run time guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tlv_field_stream_parser_unit verification failed");
            $finish;
        end
    end

    // result side stall, random or held off for a long stretch
    always @(posedge clk)
    begin
        out_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
    end

    // long receiver hold-off, counted here
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_on <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_on <= 1'b0;
                hold_request = 1'b0;
            end
        end
    end

    // parser mirror: back to header phase for a new buffer
    function automatic void restart_parse();
        parse_phase = PH_HEADER;
        hdr_count   = '0;
        type_acc    = '0;
        length_acc  = '0;
        value_left  = '0;
        field_count = '0;
    endfunction

    function automatic void push_result(kind_t k, logic [15:0] rec_type, logic [15:0] rec_len,
                                        logic [15:0] offset, logic [7:0] vbyte, logic fdone,
                                        logic pdone, status_t st);
        result_t r;
        r.kind          = k;
        r.record_type   = rec_type;
        r.record_length = rec_len;
        r.value_offset  = offset;
        r.value_byte    = vbyte;
        r.field_done    = fdone;
        r.field_number  = field_count[9:0];
        r.parse_done    = pdone;
        r.status        = st;
        expected_results = {expected_results, r};
    endfunction

    // error: status result, restart, drop the rest unless this was the final byte
    function automatic void report_parse_error(status_t st, logic last);
        push_result(KIND_STATUS, type_acc, length_acc, '0, '0, 1'b0, 1'b1, st);
        restart_parse();
        dropping = !last;
    endfunction

    // expected outcome of one accepted byte
    function automatic void predict_byte(logic [7:0] b, logic last);
        logic [1:0]  pos;
        logic [15:0] placed;
        logic [15:0] offset;
        logic [10:0] lim;
        if (dropping)
        begin
            if (last)
            begin
                dropping = 1'b0;
                restart_parse();
            end
            return;
        end
        if (parse_phase == PH_HEADER)
        begin
            pos = hdr_count;
            placed = (pos[0] ^ cfg_mirror.header_big_endian) ? {b, 8'h00} : {8'h00, b};
            lim = (int'(cfg_mirror.field_limit) < FIELD_CAP) ? cfg_mirror.field_limit
                                                              : 11'(FIELD_CAP);
            if (pos < 2)
                type_acc |= placed;
            else
                length_acc |= placed;
            if (pos != 2'd3)
            begin
                hdr_count = pos + 2'd1;
                if (last)
                begin
                    push_result(KIND_STATUS, '0, '0, '0, '0, 1'b0, 1'b1,
                                cfg_mirror.strict_end ? ST_TRUNC_HEADER : ST_OK);
                    restart_parse();
                end
                return;
            end
            hdr_count = '0;
            if (field_count >= lim)
            begin
                report_parse_error(ST_TOO_MANY, last);
                return;
            end
            if (length_acc > cfg_mirror.value_size_limit)
            begin
                report_parse_error(ST_TOO_LARGE, last);
                return;
            end
            if (length_acc == 0)
            begin
                push_result(KIND_EMPTY, type_acc, '0, '0, '0, 1'b1, last, ST_OK);
                field_count++;
                type_acc = '0;
                if (last)
                    restart_parse();
                return;
            end
            if (last)
            begin
                report_parse_error(ST_TRUNC_VALUE, 1'b1);
                return;
            end
            parse_phase = PH_VALUE;
            value_left = length_acc;
            return;
        end
        // value phase
        offset = length_acc - value_left;
        if (value_left <= 1)
        begin
            push_result(KIND_BYTE, type_acc, length_acc, offset, b, 1'b1, last, ST_OK);
            field_count++;
            parse_phase = PH_HEADER;
            hdr_count   = '0;
            type_acc    = '0;
            length_acc  = '0;
            value_left  = '0;
            if (last)
                restart_parse();
        end
        else if (last)
        begin
            push_result(KIND_BYTE, type_acc, length_acc, offset, b, 1'b0, 1'b1, ST_TRUNC_VALUE);
            restart_parse();
        end
        else
        begin
            push_result(KIND_BYTE, type_acc, length_acc, offset, b, 1'b0, 1'b0, ST_OK);
            value_left--;
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request pending: kind %0h status %0h", kind, status);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("kind", 16'(want.kind), 16'(kind));
                check_field("record_type", want.record_type, record_type);
                check_field("record_length", want.record_length, record_length);
                check_field("value_offset", want.value_offset, value_offset);
                check_field("value_byte", 16'(want.value_byte), 16'(value_byte));
                check_field("field_done", 16'(want.field_done), 16'(field_done));
                check_field("field_number", 16'(want.field_number), 16'(field_number));
                check_field("parse_done", 16'(want.parse_done), 16'(parse_done));
                check_field("status", 16'(want.status), 16'(status));
            end
        end
    end

    // offer one byte and wait until it is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_in    <= b;
        buffer_end <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (!dropping)
            items_sent++;
        predict_byte(b, last);
    endtask

    // stop offering, let every expected result drain, then settle
    task automatic wait_idle();
        in_valid   <= 1'b0;
        buffer_end <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_FIELD_LIMIT:      cfg_mirror.field_limit = value[10:0];
            REG_VALUE_SIZE_LIMIT: cfg_mirror.value_size_limit = value;
            REG_STRICT_END:       cfg_mirror.strict_end = value[0];
            REG_HEADER_BIG:       cfg_mirror.header_big_endian = value[0];
            default: ;
        endcase
    endtask

    // add one byte to the buffer under assembly
    function automatic void append_byte(logic [7:0] b);
        buffer_bytes = {buffer_bytes, b};
    endfunction

    // append one record header in the current byte order plus random value bytes
    function automatic void add_record(logic [15:0] rec_type, logic [15:0] rec_len,
                                       int value_count);
        if (cfg_mirror.header_big_endian)
        begin
            append_byte(rec_type[15:8]);
            append_byte(rec_type[7:0]);
            append_byte(rec_len[15:8]);
            append_byte(rec_len[7:0]);
        end
        else
        begin
            append_byte(rec_type[7:0]);
            append_byte(rec_type[15:8]);
            append_byte(rec_len[7:0]);
            append_byte(rec_len[15:8]);
        end
        for (int i = 0; i < value_count; i++)
            append_byte(8'($urandom_range(255)));
    endfunction

    // send the assembled buffer, end mark on its final byte
    task automatic send_buffer();
        for (int i = 0; i < buffer_bytes.size(); i++)
            send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
        buffer_bytes.delete();
    endtask

    // mostly well-formed buffers, some cut short or with trailing junk
    task automatic send_random_buffer();
        int          nrec;
        int          pick;
        int          cut;
        logic [15:0] len;
        nrec = $urandom_range(1, 6);
        for (int r = 0; r < nrec; r++)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                len = '0;
            else if (pick < 80)
                len = 16'($urandom_range(1, 6));
            else if (pick < 92)
                len = 16'($urandom_range(7, 40));
            else
                len = 16'($urandom_range(65535));
            add_record(16'($urandom_range(65535)), len, (len > 40) ? 40 : int'(len));
        end
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            cut = $urandom_range(1, buffer_bytes.size());
            buffer_bytes = buffer_bytes[0:cut-1];
        end
        else if (pick < 20)
        begin
            cut = $urandom_range(1, 3);
            for (int i = 0; i < cut; i++)
                append_byte(8'($urandom_range(255)));
        end
        send_buffer();
    endtask

    // reset settings: little-endian headers, strict end
    task automatic test_default_framing();
        // clean buffer: one-byte field, empty field, three-byte field
        add_record(16'hFFFF, 16'd1, 0);
        append_byte(8'hFF);
        add_record(16'h0000, 16'd0, 0);
        add_record(16'h1234, 16'd3, 0);
        append_byte(8'h00);
        append_byte(8'h80);
        append_byte(8'h7F);
        send_buffer();
        // partial header at the end
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);
        // header is the final request with a nonzero length
        add_record(16'h00FF, 16'd2, 0);
        send_buffer();
        // value cut short
        add_record(16'hFF00, 16'd3, 1);
        send_buffer();
    endtask

    // small limits, quiet end, high byte first
    task automatic test_limits_and_quiet_end();
        write_reg(REG_FIELD_LIMIT, 16'd1);
        write_reg(REG_VALUE_SIZE_LIMIT, 16'd4);
        write_reg(REG_STRICT_END, 16'd0);
        write_reg(REG_HEADER_BIG, 16'd1);
        // second field trips the limit mid-buffer, the rest is dropped
        add_record(16'hBEEF, 16'd0, 0);
        add_record(16'hCAFE, 16'd0, 0);
        append_byte(8'h11);
        append_byte(8'h22);
        send_buffer();
        // length above the size limit mid-buffer
        add_record(16'h0102, 16'd5, 1);
        send_buffer();
        // partial header ends quietly
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b1);
        // length right at the size limit
        add_record(16'h8001, 16'd4, 4);
        send_buffer();
    endtask

    // zero limits: field count checked before value size
    task automatic test_zero_limits();
        write_reg(REG_FIELD_LIMIT, 16'd0);
        write_reg(REG_VALUE_SIZE_LIMIT, 16'd0);
        add_record(16'h1111, 16'hFFFF, 0);
        send_buffer();
        write_reg(REG_FIELD_LIMIT, 16'd1);
        add_record(16'h2222, 16'd1, 0);
        send_buffer();
        add_record(16'h3333, 16'd0, 0);
        send_buffer();
    endtask

    // field limit above the ceiling acts as the ceiling, short buffers pass
    task automatic test_field_count_ceiling();
        write_reg(REG_FIELD_LIMIT, 16'd2047);
        write_reg(REG_VALUE_SIZE_LIMIT, 16'hFFFF);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 8; i++)
            add_record(16'($urandom_range(65535)), 16'd0, 0);
        send_buffer();
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct, input int count);
        int start;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        start = items_sent;
        while (items_sent - start < count)
            send_random_buffer();
    endtask

    // random buffers under three idle patterns and several settings
    task automatic test_random_traffic();
        write_reg(REG_FIELD_LIMIT, 16'd3);
        write_reg(REG_VALUE_SIZE_LIMIT, 16'd20);
        write_reg(REG_STRICT_END, 16'd0);
        write_reg(REG_HEADER_BIG, 16'd1);
        run_random_phase(19, 77, 360);
        write_reg(REG_FIELD_LIMIT, 16'd1024);
        write_reg(REG_VALUE_SIZE_LIMIT, 16'hFFFF);
        write_reg(REG_STRICT_END, 16'd1);
        write_reg(REG_HEADER_BIG, 16'd0);
        run_random_phase(77, 19, 360);
        write_reg(REG_FIELD_LIMIT, 16'($urandom_range(1, 8)));
        write_reg(REG_VALUE_SIZE_LIMIT, 16'($urandom_range(0, 50)));
        write_reg(REG_STRICT_END, 16'($urandom_range(1)));
        write_reg(REG_HEADER_BIG, 16'($urandom_range(1)));
        run_random_phase(0, 0, 360);
    endtask

    // receiver holds off while requests keep coming, input side must stall
    task automatic test_output_backpressure();
        wait_idle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1'b1;
        for (int i = 0; i < 3; i++)
            add_record(16'($urandom_range(65535)), 16'd20, 20);
        send_buffer();
    endtask

    // main sequence
    initial
    begin
        cfg_mirror.field_limit       = FIELD_LIMIT_RST;
        cfg_mirror.value_size_limit  = VALUE_SIZE_LIMIT_RST;
        cfg_mirror.strict_end        = 1'b1;
        cfg_mirror.header_big_endian = 1'b0;
        dropping = 1'b0;
        restart_parse();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_framing();
        test_limits_and_quiet_end();
        test_zero_limits();
        test_field_count_ceiling();
        test_random_traffic();
        test_output_backpressure();

        wait_idle();
        if (fail_count == 0)
            $display("tlv_field_stream_parser_unit verification clean");
        else
            $display("tlv_field_stream_parser_unit verification failed");
        $finish;
    end

endmodule
